>>> sv/mexp_pkg.sv
// Shared constants and payload types for the modular exponentiation core.
// No dependencies; the multiplier, the core and the checker import this package.
`default_nettype none

package mexp_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int DATA_W    = 16;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 2;
  localparam int WIDTH_DEF = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRV_EXP = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] MODULUS_RST = 16'd221;
  localparam logic [CFG_W-1:0] PUB_EXP_RST = 16'd5;
  localparam logic [CFG_W-1:0] PRV_EXP_RST = 16'd77;

  // Mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Input beat
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] value;
  } mexp_in_t;

  // Output beat
  typedef struct packed {
    logic [DATA_W-1:0] result;
  } mexp_out_t;

  // Status of the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

`default_nettype wire

>>> sv/mexp_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Payload type is a parameter; types come from mexp_pkg.
`default_nettype none

interface mexp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> sv/mexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on mexp_pkg for the status struct.
`default_nettype none

module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WIDTH-1:0]     a_i,
  input  wire logic [WIDTH-1:0]     b_i,
  input  wire logic [WIDTH-1:0]     m_i,
  output      mexp_mul_stat_t       stat_o,
  output      logic [WIDTH-1:0]     prod_o
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam int SUM_W = WIDTH + 2;

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [SUM_W-1:0] sum, m1, m2, sub1, sub2;

  // Double the accumulator, add a when the current bit of b is set, then
  // fold the sum (below 3m) back under m with one of two parallel subtractions
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + {2'b00, (a_i & {WIDTH{b_q[WIDTH-1]}})};
    m1   = {2'b00, m_i};
    m2   = {1'b0, m_i, 1'b0};
    sub1 = sum - m1;
    sub2 = sum - m2;
    if (sum >= m2) begin
      acc_d = sub2[WIDTH-1:0];
    end else if (sum >= m1) begin
      acc_d = sub1[WIDTH-1:0];
    end else begin
      acc_d = sum[WIDTH-1:0];
    end
  end

  // Control: load on start, step until the last bit, pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulator and multiplier shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

>>> sv/modular_exponentiation_core.sv
// Modular exponentiation core: left-to-right square-and-multiply over a
// shared bit-serial modular multiplier. Uses mexp_pkg, mexp_stream_if, mexp_mulmod.
//
//   channel  | direction | handshake       | payload
//   in_i     | sink      | valid / ready   | mode, value
//   out_o    | source    | valid / ready   | result
//   cfg      | input     | cfg_we_i        | cfg_idx_i, cfg_data_i
//
// One item runs from one accepted beat to the next through the reduction, the squares
// and the base products, all on the single multiplier, which retires one operand bit
// per cycle. A new beat is taken only once the item before it has left its last step.
// A modulus below 2 skips the work: the item goes straight to its last step with result 0.
// Reset is asynchronous, active low, and restores the three key registers.
// A finished result waits in the output register; the next item is taken
// meanwhile and holds in its last step until that register frees up.
`default_nettype none

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mexp_stream_if.sink            in_i,
  mexp_stream_if.source          out_o,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  localparam int CNT_W = $clog2(WIDTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [CFG_W-1:0]  modulus_q, pub_exp_q, prv_exp_q;
  logic [2:0]        state_q;
  logic [WIDTH-1:0]  mod_q, base_q, acc_q, exp_q;
  logic [CNT_W-1:0]  ecnt_q;
  logic              start_q;
  logic [DATA_W-1:0] res_q;
  logic              out_valid_q;

  mexp_in_t          in_beat;
  mexp_mul_stat_t    mul_stat;
  logic [WIDTH-1:0]  mul_a, mul_b, mul_prod;
  logic [WIDTH-1:0]  mod_w, exp_w;
  logic              in_acc, out_free, last_bit;

  assign in_beat   = in_i.payload;
  assign in_i.ready = (state_q == S_IDLE) && !mul_stat.busy;
  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign last_bit  = (ecnt_q == '0);

  assign mod_w = WIDTH'(modulus_q);
  assign exp_w = (in_beat.mode == MODE_DECRYPT) ? WIDTH'(prv_exp_q) : WIDTH'(pub_exp_q);

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      pub_exp_q <= PUB_EXP_RST;
      prv_exp_q <= PRV_EXP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS: modulus_q <= cfg_data_i;
        REG_PUB_EXP: pub_exp_q <= cfg_data_i;
        REG_PRV_EXP: prv_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Operand select: reduction is 1 * value, then squares and base products
  always_comb begin
    case (state_q)
      S_RED: begin
        mul_a = WIDTH'(1);
        mul_b = base_q;
      end
      S_MUL: begin
        mul_a = base_q;
        mul_b = acc_q;
      end
      default: begin
        mul_a = acc_q;
        mul_b = acc_q;
      end
    endcase
  end

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mod_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      ecnt_q  <= '0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ecnt_q <= CNT_W'(WIDTH - 1);
            if (mod_w < WIDTH'(2)) begin
              state_q <= S_FIN;
            end else begin
              start_q <= 1'b1;
              state_q <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_stat.done) begin
            start_q <= 1'b1;
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_stat.done) begin
            if (exp_q[WIDTH-1]) begin
              start_q <= 1'b1;
              state_q <= S_MUL;
            end else if (last_bit) begin
              state_q <= S_FIN;
            end else begin
              ecnt_q  <= ecnt_q - 1'b1;
              start_q <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            if (last_bit) begin
              state_q <= S_FIN;
            end else begin
              ecnt_q  <= ecnt_q - 1'b1;
              start_q <= 1'b1;
              state_q <= S_SQR;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers: modulus, base, accumulator, exponent shift register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mod_q  <= mod_w;
      base_q <= WIDTH'(in_beat.value);
      exp_q  <= exp_w;
      acc_q  <= (mod_w < WIDTH'(2)) ? '0 : WIDTH'(1);
    end else if (mul_stat.done) begin
      case (state_q)
        S_RED: base_q <= mul_prod;
        S_SQR: begin
          acc_q <= mul_prod;
          if (!exp_q[WIDTH-1]) begin
            exp_q <= {exp_q[WIDTH-2:0], 1'b0};
          end
        end
        S_MUL: begin
          acc_q <= mul_prod;
          exp_q <= {exp_q[WIDTH-2:0], 1'b0};
        end
        default: ;
      endcase
    end
  end

  // Output register: load from the last step, drop on delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      res_q <= DATA_W'(acc_q);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.payload.result = res_q;

endmodule

`default_nettype wire

>>> sv/mexp_checker.sv
// Port-level checker for modular_exponentiation_core, attached by bind.
// Depends on mexp_pkg for register indexes and reset values.
`default_nettype none

module mexp_checker
  import mexp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [DATA_W-1:0] out_result_i,
  input wire logic              cfg_we_i,
  input wire logic [IDX_W-1:0]  cfg_idx_i,
  input wire logic [CFG_W-1:0]  cfg_data_i
);

  logic [CFG_W-1:0] mod_q;
  logic [1:0]       pend_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track the modulus as written through the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RST;
    end else if (cfg_we_i && cfg_idx_i == REG_MODULUS) begin
      mod_q <= cfg_data_i;
    end
  end

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // The block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  // No result without an item, and at most one item in work plus one waiting
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || pend_q != 2'd0) && pend_q != 2'd3)
    else $error("result count does not match accepted items");

  // Every result is reduced below the modulus, or is 0 when the modulus is below 2
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((mod_q < CFG_W'(2)) ? (out_result_i == '0)
                                          : (CFG_W'(out_result_i) < mod_q)))
    else $error("result not reduced modulo the modulus");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.payload.result),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i)
);

`default_nettype wire
